/* rtl/pbt_pkg.sv */
// Package for the port binding table: shared widths, codes and the
// command/status structs between the controller and the datapath.
// Depends on nothing.
`default_nettype none

package pbt_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned MAX_PORT_DEF    = 16;
    localparam int unsigned HANDLE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int unsigned PORT_W      = 8;
    localparam int unsigned HFIELD_W    = 16;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [PORT_W-1:0] WILDCARD_PORT = 8'd255;

    typedef enum logic [1:0] {
        MODE_BIND_SOCK = 2'd0,
        MODE_BIND_CB   = 2'd1,
        MODE_LOOKUP    = 2'd2,
        MODE_CLOSE     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVAL   = 2'd1,
        ST_USED    = 2'd2,
        ST_ALREADY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_CLOSED   = 2'd0,
        KIND_SOCKET   = 2'd1,
        KIND_CALLBACK = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        RES_ZERO   = 2'd0,
        RES_BIND   = 2'd1,
        RES_LOOKUP = 2'd2
    } t_res_src;

    typedef struct packed {
        logic     load_item;
        logic     bind_wr;
        logic     rd_scan;
        logic     scan_clr;
        logic     scan_inc;
        logic     close_clear;
        logic     out_now;
        logic     hold;
        logic     out_hold;
        t_res_src res_src;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  h_null;
        logic  scan_last;
        logic  hit;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/pbt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module pbt_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 17
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/pbt_ctrl.sv */
// Controller state machine of the port binding table.
// Depends on pbt_pkg; drives the datapath through t_cmd and reads t_sts.
`default_nettype none

module pbt_ctrl
    import pbt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_LKDATA  = 6'b000100,
        S_CLS_RD  = 6'b001000,
        S_CLS_CMP = 6'b010000,
        S_RESP    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   finish;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        finish  = 1'b0;
        o_cmd.res_src = RES_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.mode)
                    MODE_BIND_SOCK, MODE_BIND_CB: begin
                        o_cmd.bind_wr = 1'b1;
                        o_cmd.res_src = RES_BIND;
                        finish = 1'b1;
                    end
                    MODE_LOOKUP: begin
                        n_state = S_LKDATA;
                    end
                    MODE_CLOSE: begin
                        if (i_sts.h_null) begin
                            finish = 1'b1;
                        end else begin
                            o_cmd.scan_clr = 1'b1;
                            n_state = S_CLS_RD;
                        end
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_LKDATA: begin
                o_cmd.res_src = RES_LOOKUP;
                finish = 1'b1;
            end
            S_CLS_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state = S_CLS_CMP;
            end
            S_CLS_CMP: begin
                o_cmd.rd_scan = 1'b1;
                if (i_sts.hit || i_sts.scan_last) begin
                    o_cmd.close_clear = 1'b1;
                    finish = 1'b1;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state = S_CLS_RD;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_hold = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is
        // free, and otherwise waits in the hold register.
        if (finish) begin
            if (i_sts.out_free) begin
                o_cmd.out_now = 1'b1;
                n_state = S_IDLE;
            end else begin
                o_cmd.hold = 1'b1;
                n_state = S_RESP;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/pbt_dp.sv */
// Datapath of the port binding table: item registers, slot kinds, the
// handle RAM, the wildcard slot and the output register.
// Depends on pbt_pkg and pbt_ram.
`default_nettype none

module pbt_dp
    import pbt_pkg::*;
#(
    parameter int unsigned MAX_PORT    = MAX_PORT_DEF,
    parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_sts                        o_sts,
    input  wire logic [IN_TUSER_W-1:0]  i_tuser,
    input  wire logic [IN_TDATA_W-1:0]  i_tdata,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic      [OUT_TDATA_W-1:0] o_tdata
);

    localparam int unsigned NEXACT = MAX_PORT + 1;
    localparam int unsigned AW     = $clog2(NEXACT);
    localparam int unsigned HW     = (HANDLE_BITS < HFIELD_W) ? HANDLE_BITS : HFIELD_W;

    // Item registers; only the low handle bits in use are kept.
    t_mode             r_mode;
    logic [PORT_W-1:0] r_port;
    logic [HW-1:0]     r_h;

    t_kind         r_kind [NEXACT];
    t_kind         r_any_kind;
    logic [HW-1:0] r_any_h;
    logic [AW-1:0] r_scan;

    logic          r_out_valid;
    t_status       r_out_status;
    logic [HW-1:0] r_out_sock;
    logic [HW-1:0] r_out_cb;
    t_status       r_hold_status;
    logic [HW-1:0] r_hold_sock;
    logic [HW-1:0] r_hold_cb;

    logic          port_in_range;
    logic          port_wild;
    logic [AW-1:0] port_idx;
    logic [AW-1:0] kidx;
    t_kind         k_sel;
    logic          h_null;
    logic [HW-1:0] rdata;
    logic          ram_we;
    logic          bind_ok;
    t_status       bind_status;
    t_status       busy_status;
    t_kind         new_kind;
    t_kind         cur_kind;
    logic [HW-1:0] lk_sock;
    logic [HW-1:0] lk_cb;
    t_status       res_status;
    logic [HW-1:0] res_sock;
    logic [HW-1:0] res_cb;
    logic          hit_ram;
    logic          hit_any;
    logic          scan_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode <= t_mode'(i_tuser);
            r_port <= i_tdata[PORT_W-1:0];
            r_h    <= i_tdata[PORT_W +: HW];
        end
    end

    assign port_in_range = (r_port <= PORT_W'(MAX_PORT));
    assign port_wild     = (r_port == WILDCARD_PORT);
    assign port_idx      = port_in_range ? r_port[AW-1:0] : '0;
    assign kidx          = i_cmd.rd_scan ? r_scan : port_idx;
    assign k_sel         = r_kind[kidx];
    assign h_null        = (r_h == '0);
    assign scan_last     = (r_scan == AW'(MAX_PORT));

    // Bind decision.
    always_comb begin
        busy_status = (r_mode == MODE_BIND_SOCK) ? ST_USED : ST_ALREADY;
        new_kind    = (r_mode == MODE_BIND_SOCK) ? KIND_SOCKET : KIND_CALLBACK;
        cur_kind    = port_wild ? r_any_kind : k_sel;
        if (h_null || !(port_wild || port_in_range)) begin
            bind_status = ST_INVAL;
        end else if (cur_kind != KIND_CLOSED) begin
            bind_status = busy_status;
        end else begin
            bind_status = ST_OK;
        end
    end

    assign bind_ok = (bind_status == ST_OK);
    assign ram_we  = i_cmd.bind_wr && bind_ok && !port_wild;

    pbt_ram #(
        .WIDTH (HW),
        .DEPTH (NEXACT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (port_idx),
        .i_wdata (r_h),
        .i_raddr (kidx),
        .o_rdata (rdata)
    );

    // Lookup: an exact slot of either kind hides the wildcard slot.
    always_comb begin
        lk_sock = '0;
        lk_cb   = '0;
        if (port_in_range) begin
            case (k_sel)
                KIND_SOCKET: begin
                    lk_sock = rdata;
                end
                KIND_CALLBACK: begin
                    lk_cb = rdata;
                end
                KIND_CLOSED: begin
                    if (r_any_kind == KIND_SOCKET) begin
                        lk_sock = r_any_h;
                    end
                    if (r_any_kind == KIND_CALLBACK) begin
                        lk_cb = r_any_h;
                    end
                end
                default: begin
                    lk_sock = '0;
                end
            endcase
        end
    end

    always_comb begin
        res_status = ST_OK;
        res_sock   = '0;
        res_cb     = '0;
        case (i_cmd.res_src)
            RES_BIND: begin
                res_status = bind_status;
            end
            RES_LOOKUP: begin
                res_sock = lk_sock;
                res_cb   = lk_cb;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    assign hit_ram = (k_sel == KIND_SOCKET) && (rdata == r_h);
    assign hit_any = (r_any_kind == KIND_SOCKET) && (r_any_h == r_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NEXACT; i++) begin
                r_kind[i] <= KIND_CLOSED;
            end
            r_any_kind <= KIND_CLOSED;
        end else begin
            if (i_cmd.bind_wr && bind_ok) begin
                if (port_wild) begin
                    r_any_kind <= new_kind;
                end else begin
                    r_kind[port_idx] <= new_kind;
                end
            end
            if (i_cmd.close_clear) begin
                if (hit_ram) begin
                    r_kind[r_scan] <= KIND_CLOSED;
                end else if (scan_last && hit_any) begin
                    r_any_kind <= KIND_CLOSED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bind_wr && bind_ok && port_wild) begin
            r_any_h <= r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold) begin
            r_hold_status <= res_status;
            r_hold_sock   <= res_sock;
            r_hold_cb     <= res_cb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_now) begin
            r_out_status <= res_status;
            r_out_sock   <= res_sock;
            r_out_cb     <= res_cb;
        end else if (i_cmd.out_hold) begin
            r_out_status <= r_hold_status;
            r_out_sock   <= r_hold_sock;
            r_out_cb     <= r_hold_cb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_now || i_cmd.out_hold) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.mode      = r_mode;
    assign o_sts.h_null    = h_null;
    assign o_sts.scan_last = scan_last;
    assign o_sts.hit       = hit_ram;
    assign o_sts.out_free  = !r_out_valid || i_tready;

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {6'b0, HFIELD_W'(r_out_cb), HFIELD_W'(r_out_sock), r_out_status};

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_now || i_cmd.out_hold) |-> (!r_out_valid || i_tready))
        else $error("result loaded over a pending item");

    // A successful exact bind leaves its slot open.
    a_bind_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.bind_wr && bind_ok && !port_wild) |=> (r_kind[port_idx] != KIND_CLOSED))
        else $error("bound slot still closed");

    // Exact slots hide the wildcard, so a lookup never finds both kinds.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_sock == '0 || r_out_cb == '0))
        else $error("lookup returned a socket and a callback");

    // The close scan stays within the exact slots.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= AW'(MAX_PORT))
        else $error("scan index past the last exact slot");

endmodule

`default_nettype wire

/* rtl/port_binding_table.sv */
// Port binding table: slots for ports 0..MAX_PORT plus one wildcard slot.
//
// Input stream (s_axis): one item per request. tuser carries the mode
// (bind socket, bind callback, lookup, close socket); tdata carries the
// port and the handle. Output stream (m_axis): one item per request with
// the status and the socket and callback handles found by a lookup.
// A bind, or a close with a null handle, finishes in the execute state; a
// lookup adds a state for the registered handle RAM read; a close scans
// the handle RAM one slot at a time (read, then compare) in slot order,
// wildcard last, and stops at the first match.
// The block takes one item at a time: s_axis_tready is high only in the
// idle state, between items.
// The output register and a hold register let the block finish an item
// while the receiver stalls; it then waits until the pending item is taken.
// Synchronous reset closes every slot at once and empties the output.
// Handles held by slots are not cleared and are read only for open slots.
// Depends on pbt_pkg, pbt_ctrl, pbt_dp and pbt_ram.
`default_nettype none

module port_binding_table
    import pbt_pkg::*;
#(
    parameter int unsigned MAX_PORT    = MAX_PORT_DEF,
    parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // port[7:0], handle[23:8]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,  // mode[1:0]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata   // status[1:0], socket_handle[17:2],
                                                       // callback_handle[33:18], zeros above
);

    t_cmd cmd;
    t_sts sts;

    pbt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pbt_dp #(
        .MAX_PORT    (MAX_PORT),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_tuser  (s_axis_tuser),
        .i_tdata  (s_axis_tdata),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the port binding table: drives bind, lookup and close items
// on the input stream and compares every reply against a local model of the slot table.
// Depends on pbt_pkg and port_binding_table.
`timescale 1ns / 100ps

module tb;
    import pbt_pkg::*;

    localparam int unsigned MAX_PORT    = MAX_PORT_DEF;
    localparam int unsigned NUM_SLOTS   = MAX_PORT + 2;
    localparam int unsigned ANY_SLOT    = MAX_PORT + 1;
    localparam logic [HFIELD_W-1:0] H_MASK = HFIELD_W'((64'd1 << HANDLE_BITS_DEF) - 1);
    localparam int unsigned POOL_SIZE   = 12;
    localparam int unsigned STALL_LEN   = 400;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned DRAIN_WAIT  = 40;

    typedef struct packed {
        t_status             status;
        logic [HFIELD_W-1:0] sock;
        logic [HFIELD_W-1:0] cb;
    } t_reply;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // port[7:0], handle[23:8]
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // mode[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // status[1:0], socket[17:2], callback[33:18]

    // Local copy of the slot table.
    t_kind               slot_kind   [NUM_SLOTS];
    logic [HFIELD_W-1:0] slot_handle [NUM_SLOTS];

    t_reply              replies_due [$];
    logic [HFIELD_W-1:0] handle_pool [POOL_SIZE];

    int          src_idle_pct = 0;
    int          rx_idle_pct  = 0;
    int unsigned stall_req    = 0;
    int unsigned stall_seen   = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches   = 0;
    int unsigned replies_seen = 0;
    int unsigned binds_seen   = 0;
    int unsigned binds_refused = 0;
    int unsigned lookups_seen = 0;
    int unsigned lookup_hits  = 0;
    int unsigned closes_seen  = 0;
    int unsigned closes_freed = 0;

    port_binding_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Handle of the wanted kind seen by a port; an exact slot of either kind hides the wildcard.
    function automatic logic [HFIELD_W-1:0] find_bound(logic [PORT_W-1:0] port, t_kind want);
        t_kind k;
        if (port > MAX_PORT)
            return '0;
        k = slot_kind[port];
        if (k == want)
            return slot_handle[port];
        if (k != KIND_CLOSED)
            return '0;
        if (slot_kind[ANY_SLOT] == want)
            return slot_handle[ANY_SLOT];
        return '0;
    endfunction

    function automatic t_reply predict_reply(t_mode mode, logic [PORT_W-1:0] port,
                                             logic [HFIELD_W-1:0] hin);
        t_reply              r;
        logic [HFIELD_W-1:0] h;
        int                  slot;
        logic                found;
        r = '0;
        h = hin & H_MASK;
        case (mode)
            MODE_BIND_SOCK, MODE_BIND_CB: begin
                binds_seen++;
                if (port == WILDCARD_PORT)
                    slot = ANY_SLOT;
                else if (port > MAX_PORT)
                    slot = -1;
                else
                    slot = int'(port);
                if (h == '0 || slot < 0) begin
                    r.status = ST_INVAL;
                end else if (slot_kind[slot] != KIND_CLOSED) begin
                    if (mode == MODE_BIND_SOCK)
                        r.status = ST_USED;
                    else
                        r.status = ST_ALREADY;
                end else begin
                    if (mode == MODE_BIND_SOCK)
                        slot_kind[slot] = KIND_SOCKET;
                    else
                        slot_kind[slot] = KIND_CALLBACK;
                    slot_handle[slot] = h;
                end
                if (r.status != ST_OK)
                    binds_refused++;
            end
            MODE_LOOKUP: begin
                lookups_seen++;
                r.sock = find_bound(port, KIND_SOCKET);
                r.cb   = find_bound(port, KIND_CALLBACK);
                if (r.sock != '0 || r.cb != '0)
                    lookup_hits++;
            end
            default: begin
                closes_seen++;
                found = 1'b0;
                if (h != '0) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!found && slot_kind[i] == KIND_SOCKET && slot_handle[i] == h) begin
                            slot_kind[i]   = KIND_CLOSED;
                            slot_handle[i] = '0;
                            found          = 1'b1;
                        end
                    end
                end
                if (found)
                    closes_freed++;
            end
        endcase
        return r;
    endfunction

    // Offers one item, with random idle cycles first, and records its reply once accepted.
    task automatic send_request(t_mode mode, logic [PORT_W-1:0] port,
                                logic [HFIELD_W-1:0] handle);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'($urandom);
            s_axis_tuser  <= IN_TUSER_W'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {handle, port};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        replies_due.push_back(predict_reply(mode, port, handle));
    endtask

    // Mostly valid ports and handles from a small pool, so that binds collide and closes hit.
    // Callback binds go only to the top exact ports or to invalid ports, as nothing ever frees a callback slot.
    task automatic send_random_request();
        int unsigned         pick;
        t_mode               mode;
        logic [PORT_W-1:0]   port;
        logic [HFIELD_W-1:0] handle;
        pick = $urandom_range(99);
        if (pick < 36)
            mode = MODE_BIND_SOCK;
        else if (pick < 40)
            mode = MODE_BIND_CB;
        else if (pick < 72)
            mode = MODE_LOOKUP;
        else
            mode = MODE_CLOSE;
        pick = $urandom_range(99);
        if (mode == MODE_BIND_CB) begin
            if (pick < 60)
                port = PORT_W'($urandom_range(MAX_PORT, MAX_PORT - 2));
            else
                port = PORT_W'($urandom_range(254, MAX_PORT + 1));
        end else if (pick < 75) begin
            port = PORT_W'($urandom_range(MAX_PORT, 0));
        end else if (pick < 85) begin
            port = WILDCARD_PORT;
        end else begin
            port = PORT_W'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 5)
            handle = '0;
        else if (pick < 15)
            handle = HFIELD_W'($urandom);
        else
            handle = handle_pool[$urandom_range(POOL_SIZE - 1, 0)];
        send_request(mode, port, handle);
    endtask

    task automatic flag_mismatch(string field, logic [HFIELD_W-1:0] want,
                                 logic [HFIELD_W-1:0] got);
        if (mismatches < 10)
            $display("reply %0d: %s mismatch, expected %h, got %h",
                     replies_seen, field, want, got);
        mismatches++;
    endtask

    task automatic test_directed();
        send_request(MODE_BIND_SOCK, 8'd0, 16'hFFFF);
        send_request(MODE_BIND_SOCK, PORT_W'(MAX_PORT), 16'h0001);
        send_request(MODE_BIND_SOCK, PORT_W'(MAX_PORT + 1), 16'h0005);
        send_request(MODE_BIND_SOCK, 8'd254, 16'h0005);
        send_request(MODE_BIND_SOCK, 8'd3, 16'h0000);
        send_request(MODE_BIND_SOCK, 8'd0, 16'h1234);
        send_request(MODE_BIND_CB, 8'd0, 16'h2222);
        send_request(MODE_BIND_CB, PORT_W'(MAX_PORT - 1), 16'h8000);
        send_request(MODE_BIND_CB, PORT_W'(MAX_PORT), 16'h3333);
        send_request(MODE_BIND_SOCK, WILDCARD_PORT, 16'hA5A5);
        send_request(MODE_BIND_SOCK, WILDCARD_PORT, 16'h0001);
        send_request(MODE_LOOKUP, 8'd0, HFIELD_W'($urandom));
        // The exact callback slot hides the wildcard socket here.
        send_request(MODE_LOOKUP, PORT_W'(MAX_PORT - 1), HFIELD_W'($urandom));
        send_request(MODE_LOOKUP, 8'd5, HFIELD_W'($urandom));
        send_request(MODE_LOOKUP, PORT_W'(MAX_PORT + 1), HFIELD_W'($urandom));
        send_request(MODE_LOOKUP, WILDCARD_PORT, HFIELD_W'($urandom));
        send_request(MODE_CLOSE, 8'd0, 16'h0000);
        send_request(MODE_CLOSE, 8'd9, 16'h4444);
        send_request(MODE_BIND_SOCK, 8'd7, 16'hFFFF);
        // Two slots hold the same handle: only the lower port is freed.
        send_request(MODE_CLOSE, 8'd200, 16'hFFFF);
        send_request(MODE_LOOKUP, 8'd0, 16'h0000);
        send_request(MODE_LOOKUP, 8'd7, 16'h0000);
        send_request(MODE_CLOSE, 8'd0, 16'hA5A5);
        send_request(MODE_LOOKUP, 8'd5, 16'h0000);
        send_request(MODE_CLOSE, 8'd0, 16'h8000);
    endtask

    task automatic test_random_traffic(int unsigned count, int tx_pct, int rx_pct);
        src_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        repeat (count)
            send_random_request();
    endtask

    // A callback on the wildcard slot can never be freed, so this runs after the random part.
    task automatic test_wildcard_callback();
        src_idle_pct = 5;
        rx_idle_pct <= 20;
        while (slot_kind[ANY_SLOT] == KIND_SOCKET)
            send_request(MODE_CLOSE, PORT_W'($urandom), slot_handle[ANY_SLOT]);
        send_request(MODE_BIND_CB, WILDCARD_PORT, 16'h5A5A);
        send_request(MODE_BIND_SOCK, WILDCARD_PORT, 16'h0F0F);
        send_request(MODE_BIND_CB, WILDCARD_PORT, 16'h0F0F);
        send_request(MODE_BIND_SOCK, 8'd2, 16'h0202);
        for (int p = 0; p <= MAX_PORT; p++)
            send_request(MODE_LOOKUP, PORT_W'(p), HFIELD_W'($urandom));
        send_request(MODE_LOOKUP, WILDCARD_PORT, 16'h0000);
    endtask

    // The receiver stops for a long stretch while items keep coming, so the input backs up.
    task automatic test_backpressure();
        src_idle_pct = 0;
        rx_idle_pct <= 0;
        stall_req   <= stall_req + 1;
        repeat (60)
            send_random_request();
    endtask

    always @(posedge i_clk) begin
        if (stall_req != stall_seen) begin
            stall_seen    <= stall_req;
            stall_left    <= STALL_LEN;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (replies_due.size() == 0) begin
                flag_mismatch("unexpected reply", '0, m_axis_tdata[17:2]);
            end else begin
                want = replies_due.pop_front();
                if (m_axis_tdata[1:0] != want.status)
                    flag_mismatch("status", HFIELD_W'(want.status), HFIELD_W'(m_axis_tdata[1:0]));
                if (m_axis_tdata[17:2] != want.sock)
                    flag_mismatch("socket handle", want.sock, m_axis_tdata[17:2]);
                if (m_axis_tdata[33:18] != want.cb)
                    flag_mismatch("callback handle", want.cb, m_axis_tdata[33:18]);
                if (m_axis_tdata[OUT_TDATA_W-1:34] != '0)
                    flag_mismatch("padding", '0, HFIELD_W'(m_axis_tdata[OUT_TDATA_W-1:34]));
            end
            replies_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_kind[i]   = KIND_CLOSED;
            slot_handle[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            handle_pool[i] = HFIELD_W'($urandom_range(65535, 1));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(380, 10, 48);
        test_random_traffic(380, 48, 10);
        test_random_traffic(380, 0, 0);
        test_wildcard_callback();
        test_backpressure();
        s_axis_tvalid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d items: %0d binds (%0d refused), %0d lookups (%0d found a handle),",
                 binds_seen + lookups_seen + closes_seen, binds_seen, binds_refused,
                 lookups_seen, lookup_hits);
        $display("%0d closes (%0d freed a slot), %0d replies checked, %0d mismatches",
                 closes_seen, closes_freed, replies_seen, mismatches);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* port_binding_table.f */
rtl/pbt_pkg.sv
rtl/pbt_ram.sv
rtl/pbt_ctrl.sv
rtl/pbt_dp.sv
rtl/port_binding_table.sv
bench/tb.sv
